@@ design/pngain_pkg.sv @@
// Package for the peak normalising gain stage.
// Holds field widths, item and register codes, and the control/status structs.
// No dependencies.
package pngain_pkg;

  // Fixed field widths
  localparam int GAIN_W = 22;
  localparam int KIND_W = 2;
  localparam int MODE_W = 2;
  localparam int IDX_W  = 2;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_SCAN   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FINISH = 2'd1;
  localparam logic [KIND_W-1:0] KIND_APPLY  = 2'd2;

  // Gain modes (code 3 behaves as unity)
  localparam logic [MODE_W-1:0] MODE_UNITY  = 2'd0;
  localparam logic [MODE_W-1:0] MODE_MANUAL = 2'd1;
  localparam logic [MODE_W-1:0] MODE_AUTO   = 2'd2;

  // Configuration register indexes
  localparam logic [IDX_W-1:0] REG_GAIN_MODE    = 2'd0;
  localparam logic [IDX_W-1:0] REG_MANUAL_GAIN  = 2'd1;
  localparam logic [IDX_W-1:0] REG_TARGET_LEVEL = 2'd2;

  // Commands from controller to datapath
  typedef struct packed {
    logic scan;       // fold sample into running peak
    logic mul_load;   // register sample times gain in use
    logic fin_load;   // start finish: latch gain source, set up divider, clear peak
    logic div_step;   // one quotient bit
    logic out_apply;  // load result register with gained sample
    logic out_fin;    // commit new gain and load result register
  } ctrl_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_free;   // result register may be loaded this cycle
    logic auto_sel;   // gain mode is automatic
    logic div_last;   // divider performs its last step this cycle
  } stat_t;

endpackage

@@ design/pngain_if.sv @@
// Stream interfaces for the gain stage: request channel and result channel.
// Depends on pngain_pkg.
interface pngain_in_if #(
  parameter int SAMPLE_BITS = 16
);
  import pngain_pkg::*;

  logic                          valid;
  logic                          ready;
  logic [KIND_W-1:0]             kind;
  logic signed [SAMPLE_BITS-1:0] sample_in;

  modport source (output valid, kind, sample_in, input ready);
  modport sink   (input valid, kind, sample_in, output ready);
endinterface

interface pngain_out_if #(
  parameter int SAMPLE_BITS = 16
);
  import pngain_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic [GAIN_W-1:0]             gain_now;
  logic                          clipped;

  modport source (output valid, sample_out, gain_now, clipped, input ready);
  modport sink   (input valid, sample_out, gain_now, clipped, output ready);
endinterface

@@ design/peak_normalize_gain.sv @@
// Peak normalising gain stage. Scan folds a sample into the peak. Apply: multiply, then
// round/saturate. Finish: setup, then commit; in automatic mode the restoring divider
// runs between them, giving one quotient bit per cycle. The result register lets a scan
// proceed while a result waits.
// Synchronous active-low reset: unity gain, peak cleared, default configuration.
module peak_normalize_gain #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12
) (
  input  logic                                      clk,
  input  logic                                      rst_n,
  pngain_in_if.sink                                 in_chan,
  pngain_out_if.source                              out_chan,
  input  logic                                      cfg_we,
  input  logic [pngain_pkg::IDX_W-1:0]              cfg_index,
  input  logic [((pngain_pkg::GAIN_W > SAMPLE_BITS - 1) ?
                 pngain_pkg::GAIN_W : SAMPLE_BITS - 1)-1:0] cfg_data
);
  import pngain_pkg::*;

  localparam int CFG_W = (GAIN_W > SAMPLE_BITS - 1) ? GAIN_W : SAMPLE_BITS - 1;

  ctrl_t cmd;
  stat_t st;

  // Sequencer
  pngain_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_kind  (in_chan.kind),
    .in_ready (in_chan.ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Arithmetic and state
  pngain_dp #(
    .SAMPLE_BITS    (SAMPLE_BITS),
    .GAIN_FRAC_BITS (GAIN_FRAC_BITS),
    .CFG_W          (CFG_W)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_sample   (in_chan.sample_in),
    .cmd         (cmd),
    .st          (st),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_sample  (out_chan.sample_out),
    .out_gain    (out_chan.gain_now),
    .out_clipped (out_chan.clipped)
  );

endmodule

@@ design/pngain_ctrl.sv @@
// Controller state machine of the gain stage: sequences scan, apply and finish requests.
// Depends on pngain_pkg; drives the datapath through ctrl_t, reads stat_t.
module pngain_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  logic [pngain_pkg::KIND_W-1:0]      in_kind,
  output logic                               in_ready,
  input  pngain_pkg::stat_t                  st,
  output pngain_pkg::ctrl_t                  cmd
);
  import pngain_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_APPLY = 2'd1;
  localparam logic [1:0] S_DIV   = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  // Take a request only when idle
  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_kind)
            KIND_SCAN: begin
              cmd.scan = 1'b1;
            end
            KIND_APPLY: begin
              cmd.mul_load = 1'b1;
              state_nxt    = S_APPLY;
            end
            KIND_FINISH: begin
              cmd.fin_load = 1'b1;
              state_nxt    = st.auto_sel ? S_DIV : S_FIN;
            end
            default: begin
              // drop requests of no meaning
            end
          endcase
        end
      end
      S_APPLY: begin
        if (st.out_free) begin
          cmd.out_apply = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (st.div_last) begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (st.out_free) begin
          cmd.out_fin = 1'b1;
          state_nxt   = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.scan, cmd.mul_load, cmd.fin_load, cmd.div_step, cmd.out_apply,
              cmd.out_fin}))
    else $error("controller issued more than one command");

  // Divider keeps running until its last step
  a_div_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV && !st.div_last) |=> state_r == S_DIV)
    else $error("division left early");

  // An apply result always follows its multiply
  a_apply_seq: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mul_load |=> state_r == S_APPLY)
    else $error("multiply not followed by apply stage");

endmodule

@@ design/pngain_dp.sv @@
// Datapath of the gain stage: configuration, peak tracker, gain multiplier,
// one-bit-per-cycle restoring divider and result register.
// Depends on pngain_pkg; driven by pngain_ctrl through ctrl_t.
module pngain_dp #(
  parameter int SAMPLE_BITS    = 16,
  parameter int GAIN_FRAC_BITS = 12,
  parameter int CFG_W          = 22
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_we,
  input  logic [pngain_pkg::IDX_W-1:0]       cfg_index,
  input  logic [CFG_W-1:0]                   cfg_data,
  input  logic signed [SAMPLE_BITS-1:0]      in_sample,
  input  pngain_pkg::ctrl_t                  cmd,
  output pngain_pkg::stat_t                  st,
  input  logic                               out_ready,
  output logic                               out_valid,
  output logic signed [SAMPLE_BITS-1:0]      out_sample,
  output logic [pngain_pkg::GAIN_W-1:0]      out_gain,
  output logic                               out_clipped
);
  import pngain_pkg::*;

  localparam int SB        = SAMPLE_BITS;
  localparam int GF        = GAIN_FRAC_BITS;
  localparam int TGT_W     = SB - 1;
  localparam int FULL      = 1 << (SB - 1);
  localparam int NOISE_MAX = FULL / 1000;
  localparam int FLOOR_PK  = (FULL + 5) / 10;
  localparam int TGT_DEF   = (SB >= 16) ? (23170 << (SB - 16)) : (23170 >> (16 - SB));
  localparam int ND        = TGT_W + GF + 1;
  localparam int QW        = (ND > GAIN_W + 1) ? ND : GAIN_W + 1;
  localparam int CW        = $clog2(QW + 1);
  localparam int PW        = SB + GAIN_W + 1;
  localparam int RW        = PW - GF;

  localparam logic [GAIN_W-1:0] UNITY    = GAIN_W'(1 << GF);
  localparam logic [GAIN_W-1:0] GAIN_MAX = '1;
  localparam logic [CW-1:0]     DIV_LAST = CW'(QW - 1);
  localparam logic [CW-1:0]     DIV_DONE = CW'(QW);
  localparam logic [PW-1:0]     RND_HALF = PW'(1) << (GF - 1);

  // Configuration registers
  logic [MODE_W-1:0] mode_r;
  logic [GAIN_W-1:0] manual_r;
  logic [TGT_W-1:0]  target_r;

  // Gain state
  logic [SB-1:0]     peak_r;
  logic [GAIN_W-1:0] gain_value_r;
  logic              gain_ready_r;

  // Finish working registers
  logic              auto_r;
  logic [GAIN_W-1:0] fixed_r;
  logic [SB-1:0]     rem_r;
  logic [SB-1:0]     dsr_r;
  logic [QW-1:0]     quo_r;
  logic [CW-1:0]     cnt_r;

  // Apply working registers
  logic signed [PW-1:0] prod_r;
  logic [GAIN_W-1:0]    gain_used_r;

  // Result register
  logic                 out_valid_r;
  logic signed [SB-1:0] out_sample_r;
  logic [GAIN_W-1:0]    out_gain_r;
  logic                 out_clipped_r;

  logic [SB-1:0]     abs_s;
  logic [GAIN_W-1:0] gain_use;
  logic [SB-1:0]     pk_eff;
  logic [QW-1:0]     dividend;
  logic [SB:0]       trial;
  logic [SB:0]       diff;
  logic [GAIN_W-1:0] auto_gain;
  logic [PW-1:0]     rnd_sum;
  logic [RW-1:0]     rnd;
  logic              ovf;
  logic [SB-1:0]     sat_val;
  logic              out_load;

  // Absolute value of the incoming sample (full-scale negative fits unsigned)
  assign abs_s = in_sample[SB-1] ? (~in_sample + SB'(1)) : in_sample;

  // Gain used by apply requests
  always_comb begin
    case (mode_r)
      MODE_MANUAL: gain_use = manual_r;
      MODE_AUTO:   gain_use = gain_ready_r ? gain_value_r : UNITY;
      default:     gain_use = UNITY;
    endcase
  end

  // Noise floor substitution and rounded dividend
  assign pk_eff   = (peak_r <= SB'(NOISE_MAX)) ? SB'(FLOOR_PK) : peak_r;
  assign dividend = (QW'(target_r) << GF) + QW'(pk_eff >> 1);

  // Restoring division step
  assign trial = {rem_r, quo_r[QW-1]};
  assign diff  = trial - {1'b0, dsr_r};

  // Saturate quotient to gain width
  assign auto_gain = (quo_r[QW-1:GAIN_W] != '0) ? GAIN_MAX : quo_r[GAIN_W-1:0];

  // Round half up, then saturate to the sample width
  assign rnd_sum = prod_r + RND_HALF;
  assign rnd     = rnd_sum[PW-1:GF];
  assign ovf     = (rnd[RW-1:SB-1] != '0) && (rnd[RW-1:SB-1] != '1);
  assign sat_val = rnd[RW-1] ? {1'b1, {(SB-1){1'b0}}} : {1'b0, {(SB-1){1'b1}}};

  assign out_load    = cmd.out_apply || cmd.out_fin;
  assign st.out_free = !out_valid_r || out_ready;
  assign st.auto_sel = (mode_r == MODE_AUTO);
  assign st.div_last = (cnt_r == DIV_LAST);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_UNITY;
      manual_r <= UNITY;
      target_r <= TGT_W'(TGT_DEF);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_GAIN_MODE:    mode_r   <= cfg_data[MODE_W-1:0];
        REG_MANUAL_GAIN:  manual_r <= cfg_data[GAIN_W-1:0];
        REG_TARGET_LEVEL: target_r <= cfg_data[TGT_W-1:0];
        default: begin
          // ignore writes beyond the register list
        end
      endcase
    end
  end

  // Peak tracker and gain state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      peak_r       <= '0;
      gain_value_r <= UNITY;
      gain_ready_r <= 1'b0;
    end else begin
      if (cmd.scan && (abs_s > peak_r)) begin
        peak_r <= abs_s;
      end else if (cmd.fin_load) begin
        peak_r <= '0;
      end
      if (cmd.out_fin) begin
        gain_value_r <= auto_r ? auto_gain : fixed_r;
        gain_ready_r <= 1'b1;
      end
    end
  end

  // Divider step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.fin_load) begin
      cnt_r <= '0;
    end else if (cmd.div_step) begin
      cnt_r <= cnt_r + CW'(1);
    end
  end

  // Finish setup and division datapath
  always_ff @(posedge clk) begin
    if (cmd.fin_load) begin
      auto_r  <= (mode_r == MODE_AUTO);
      fixed_r <= (mode_r == MODE_MANUAL) ? manual_r : UNITY;
      rem_r   <= '0;
      dsr_r   <= pk_eff;
      quo_r   <= dividend;
    end else if (cmd.div_step) begin
      if (!diff[SB]) begin
        rem_r <= diff[SB-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= trial[SB-1:0];
        quo_r <= {quo_r[QW-2:0], 1'b0};
      end
    end
  end

  // Multiply sample by the gain in use
  always_ff @(posedge clk) begin
    if (cmd.mul_load) begin
      prod_r      <= PW'(in_sample) * PW'($signed({1'b0, gain_use}));
      gain_used_r <= gain_use;
    end
  end

  // Result register: hold until taken, load when free
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_apply) begin
      out_sample_r  <= ovf ? sat_val : rnd[SB-1:0];
      out_gain_r    <= gain_used_r;
      out_clipped_r <= ovf;
    end else if (cmd.out_fin) begin
      out_sample_r  <= '0;
      out_gain_r    <= auto_r ? auto_gain : fixed_r;
      out_clipped_r <= 1'b0;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_sample  = out_sample_r;
  assign out_gain    = out_gain_r;
  assign out_clipped = out_clipped_r;

  // Automatic gain is committed only once every quotient bit is in
  a_div_complete: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.out_fin && auto_r) |-> cnt_r == DIV_DONE)
    else $error("gain committed before division finished");

  // Never overwrite a result that has not been taken
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_load |-> st.out_free)
    else $error("result register overwritten");

  // A finish leaves the gain marked ready and a result waiting
  a_fin_commit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_fin |=> (gain_ready_r && out_valid_r))
    else $error("finish did not commit gain");

endmodule

@@ test/testbench.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for peak_normalize_gain: directed and random requests with
// random idling on both channels, checked against a cycle-free gain stage predictor.
// Depends on pngain_pkg, the pngain_in_if/pngain_out_if interfaces and the block's RTL.
module testbench;
  import pngain_pkg::*;

  localparam int SAMPLE_W       = 16;
  localparam int FRAC_W         = 12;
  localparam int CFG_W          = 22;
  localparam int TARGET_W       = 15;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RANDOM_ITEMS   = 400;

  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

  localparam logic [GAIN_W-1:0]   UNITY      = 22'd4096;
  localparam logic [GAIN_W-1:0]   GAIN_TOP   = '1;
  localparam logic [TARGET_W-1:0] TARGET_TOP = '1;
  localparam longint FULL_SCALE = 32768;
  localparam longint FLOOR_PEAK = (FULL_SCALE + 5) / 10;

  localparam logic [2:0] SET_MODE   = 3'b001;
  localparam logic [2:0] SET_MANUAL = 3'b010;
  localparam logic [2:0] SET_TARGET = 3'b100;
  localparam logic [2:0] SET_ALL    = 3'b111;

  typedef struct packed {
    logic [KIND_W-1:0]          kind;
    logic signed [SAMPLE_W-1:0] sample;
  } request_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] sample;
    logic [GAIN_W-1:0]          gain;
    logic                       clip;
  } gained_t;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  pngain_in_if  #(.SAMPLE_BITS(SAMPLE_W)) req_if ();
  pngain_out_if #(.SAMPLE_BITS(SAMPLE_W)) res_if ();

  peak_normalize_gain #(
    .SAMPLE_BITS    (SAMPLE_W),
    .GAIN_FRAC_BITS (FRAC_W)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (req_if),
    .out_chan  (res_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register mirror and gain stage state as the predictor sees them
  logic [MODE_W-1:0]   mode_reg;
  logic [GAIN_W-1:0]   manual_reg;
  logic [TARGET_W-1:0] target_reg;
  logic [15:0]         peak_lvl;
  logic [GAIN_W-1:0]   gain_val;
  logic                gain_set;

  request_t requests_pending[$];
  gained_t  results_due[$];
  request_t next_req;
  gained_t  seen_res;
  gained_t  due_res;

  int   errors;
  int   items_queued;
  int   idle_left;
  int   stall_left;
  int   idle_pct;
  int   stall_pct;
  logic req_taken;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

  // Gain for automatic mode: target over peak, with quiet peaks lifted to the floor
  function automatic logic [GAIN_W-1:0] normalising_gain();
    longint pk;
    longint q;
    pk = longint'(peak_lvl);
    if (pk * 1000 <= FULL_SCALE)
      pk = FLOOR_PEAK;
    q = ((longint'(target_reg) << FRAC_W) + pk / 2) / pk;
    return (q > longint'(GAIN_TOP)) ? GAIN_TOP : q[GAIN_W-1:0];
  endfunction

  // Advance the predicted state by one accepted request and queue its result, if any
  task automatic step_gain_stage(input request_t req);
    int      s;
    int      a;
    longint  g;
    longint  r;
    gained_t res;
    s = int'(req.sample);
    res = '0;
    case (req.kind)
      KIND_SCAN: begin
        a = (s < 0) ? -s : s;
        if (a > int'(peak_lvl))
          peak_lvl = a[15:0];
      end
      KIND_FINISH: begin
        case (mode_reg)
          MODE_AUTO:   gain_val = normalising_gain();
          MODE_MANUAL: gain_val = manual_reg;
          default:     gain_val = UNITY;
        endcase
        gain_set = 1'b1;
        peak_lvl = '0;
        res.gain = gain_val;
        results_due.push_back(res);
      end
      KIND_APPLY: begin
        if (mode_reg == MODE_MANUAL)
          g = longint'(manual_reg);
        else if (mode_reg == MODE_AUTO && gain_set)
          g = longint'(gain_val);
        else
          g = longint'(UNITY);
        // round half up, then saturate to the sample range
        r = (longint'(s) * g + (longint'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (r > FULL_SCALE - 1) begin
          r = FULL_SCALE - 1;
          res.clip = 1'b1;
        end else if (r < -FULL_SCALE) begin
          r = -FULL_SCALE;
          res.clip = 1'b1;
        end
        res.sample = r[SAMPLE_W-1:0];
        res.gain   = g[GAIN_W-1:0];
        results_due.push_back(res);
      end
      default: ;
    endcase
  endtask

  // Predict on accepted requests, check accepted results against the oldest expectation
  always @(posedge clk) begin
    if (!rst_n) begin
      req_taken <= 1'b0;
    end else begin
      req_taken <= req_if.valid && req_if.ready;
      if (res_if.valid && res_if.ready) begin
        seen_res.sample = res_if.sample_out;
        seen_res.gain   = res_if.gain_now;
        seen_res.clip   = res_if.clipped;
        if (results_due.size() == 0) begin
          errors++;
          $display("%0t: result with none expected: sample %0d gain %0d clip %0b",
                   $time, seen_res.sample, seen_res.gain, seen_res.clip);
        end else begin
          due_res = results_due.pop_front();
          if (seen_res.sample !== due_res.sample || seen_res.gain !== due_res.gain ||
              seen_res.clip !== due_res.clip) begin
            errors++;
            $display("%0t: mismatch: expected sample %0d gain %0d clip %0b,",
                     $time, due_res.sample, due_res.gain, due_res.clip,
                     " got sample %0d gain %0d clip %0b",
                     seen_res.sample, seen_res.gain, seen_res.clip);
          end
        end
      end
      if (req_if.valid && req_if.ready)
        step_gain_stage(request_t'{kind: req_if.kind, sample: req_if.sample_in});
    end
  end

  // Drive requests from the pending queue and the result ready, with idle bursts
  always @(negedge clk) begin
    if (!rst_n) begin
      req_if.valid <= 1'b0;
      res_if.ready <= 1'b0;
    end else begin
      if (!req_if.valid || req_taken) begin
        if (idle_left > 0) begin
          req_if.valid <= 1'b0;
          idle_left--;
        end else if (requests_pending.size() > 0) begin
          next_req = requests_pending.pop_front();
          req_if.valid     <= 1'b1;
          req_if.kind      <= next_req.kind;
          req_if.sample_in <= next_req.sample;
          if ($urandom_range(0, 99) < idle_pct)
            idle_left = $urandom_range(1, 4);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        res_if.ready <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        res_if.ready <= 1'b1;
      end
    end
  end

  task automatic queue_request(input logic [KIND_W-1:0] kind,
                               input logic signed [SAMPLE_W-1:0] sample);
    requests_pending.push_back(request_t'{kind: kind, sample: sample});
    if (kind != KIND_SPARE)
      items_queued++;
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_GAIN_MODE:    mode_reg   = data[MODE_W-1:0];
      REG_MANUAL_GAIN:  manual_reg = data[GAIN_W-1:0];
      REG_TARGET_LEVEL: target_reg = data[TARGET_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [2:0] mask, input logic [MODE_W-1:0] mode,
                            input logic [GAIN_W-1:0] manual,
                            input logic [TARGET_W-1:0] target);
    if (mask[0])
      write_reg(REG_GAIN_MODE, CFG_W'(mode));
    if (mask[1])
      write_reg(REG_MANUAL_GAIN, CFG_W'(manual));
    if (mask[2])
      write_reg(REG_TARGET_LEVEL, CFG_W'(target));
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Hold until every request is taken and every result seen, then let a finish settle
  task automatic drain();
    while (requests_pending.size() != 0 || req_if.valid || results_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(input bit quiet);
    case ($urandom_range(0, 7))
      0: begin
        case ($urandom_range(0, 3))
          0:       return 16'sh7FFF;
          1:       return 16'sh8000;
          2:       return 16'sh0000;
          default: return 16'shFFFF;
        endcase
      end
      1, 2:    return SAMPLE_W'($urandom_range(0, 80) - 40);
      default: return quiet ? SAMPLE_W'($urandom_range(0, 70) - 35) : SAMPLE_W'($urandom);
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0]   mode_pick;
    logic [GAIN_W-1:0]   manual_pick;
    logic [TARGET_W-1:0] target_pick;
    bit                  quiet;
    int                  kind_pick;

    req_if.valid     = 1'b0;
    req_if.kind      = KIND_SCAN;
    req_if.sample_in = '0;
    res_if.ready     = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = REG_GAIN_MODE;
    cfg_data         = '0;
    rst_n            = 1'b0;
    errors           = 0;
    items_queued     = 0;
    idle_left        = 0;
    stall_left       = 0;
    idle_pct         = 30;
    stall_pct        = 30;
    mode_reg         = MODE_UNITY;
    manual_reg       = UNITY;
    target_reg       = 15'd23170;
    peak_lvl         = '0;
    gain_val         = UNITY;
    gain_set         = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Automatic mode on the reset target: unity before the first finish, full-scale
    // negative peak, an ignored kind, a finish with no scans and the noise floor edge
    set_config(SET_MODE, MODE_AUTO, '0, '0);
    queue_request(KIND_APPLY, 16'sd16384);
    queue_request(KIND_APPLY, 16'sh8000);
    queue_request(KIND_SCAN, 16'sh8000);
    queue_request(KIND_SPARE, 16'sh7FFF);
    queue_request(KIND_FINISH, 16'sd0);
    queue_request(KIND_APPLY, 16'sh7FFF);
    queue_request(KIND_FINISH, 16'sh7FFF);
    queue_request(KIND_SCAN, 16'sd32);
    queue_request(KIND_FINISH, 16'sd0);
    queue_request(KIND_SCAN, -16'sd33);
    queue_request(KIND_FINISH, 16'sd0);
    queue_request(KIND_APPLY, -16'sd1);
    drain();

    // Largest manual gain clips both ways; a half gain shows the rounding direction
    set_config(SET_ALL, MODE_MANUAL, GAIN_TOP, TARGET_TOP);
    queue_request(KIND_APPLY, 16'sh7FFF);
    queue_request(KIND_APPLY, 16'sh8000);
    queue_request(KIND_APPLY, 16'sd1);
    queue_request(KIND_FINISH, 16'sd0);
    drain();
    set_config(SET_MANUAL, MODE_MANUAL, 22'd2048, TARGET_TOP);
    queue_request(KIND_APPLY, 16'sd1);
    queue_request(KIND_APPLY, -16'sd1);
    drain();

    // Spare mode acts as unity; zero target; largest gain from the smallest peak
    set_config(SET_ALL, MODE_SPARE, '0, '0);
    queue_request(KIND_APPLY, 16'sd12345);
    queue_request(KIND_FINISH, 16'sd0);
    drain();
    set_config(SET_MODE, MODE_AUTO, '0, '0);
    queue_request(KIND_SCAN, 16'sd1000);
    queue_request(KIND_FINISH, 16'sd0);
    queue_request(KIND_APPLY, 16'sh7FFF);
    drain();
    set_config(SET_TARGET, MODE_AUTO, '0, TARGET_TOP);
    queue_request(KIND_SCAN, 16'sd33);
    queue_request(KIND_FINISH, 16'sd0);
    queue_request(KIND_APPLY, 16'sh7FFF);
    drain();

    // Random phases: scan runs, a finish, apply runs, with some stray requests
    items_queued = 0;
    while (items_queued < RANDOM_ITEMS) begin
      if (items_queued > RANDOM_ITEMS * 4 / 5) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else if ($urandom_range(0, 3) == 0) begin
        idle_pct  = 0;
        stall_pct = 0;
      end else begin
        idle_pct  = $urandom_range(10, 50);
        stall_pct = $urandom_range(10, 50);
      end
      mode_pick = MODE_W'($urandom_range(0, 3));
      case ($urandom_range(0, 7))
        0:       manual_pick = '0;
        1:       manual_pick = GAIN_TOP;
        2:       manual_pick = UNITY;
        3:       manual_pick = GAIN_W'($urandom_range(0, GAIN_TOP));
        default: manual_pick = GAIN_W'($urandom_range(0, 16383));
      endcase
      case ($urandom_range(0, 5))
        0:       target_pick = '0;
        1:       target_pick = TARGET_TOP;
        default: target_pick = TARGET_W'($urandom_range(0, TARGET_TOP));
      endcase
      set_config(SET_ALL, mode_pick, manual_pick, target_pick);
      repeat ($urandom_range(2, 4)) begin
        if ($urandom_range(0, 5) == 0) begin
          kind_pick = $urandom_range(0, 3);
          queue_request(KIND_W'(kind_pick), pick_sample(1'b0));
        end
        quiet = ($urandom_range(0, 4) == 0);
        repeat ($urandom_range(1, 16))
          queue_request(KIND_SCAN, pick_sample(quiet));
        queue_request(KIND_FINISH, SAMPLE_W'($urandom));
        repeat ($urandom_range(1, 10))
          queue_request(KIND_APPLY, pick_sample(1'b0));
      end
      drain();
    end

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/pngain_pkg.sv
design/pngain_if.sv
design/pngain_ctrl.sv
design/pngain_dp.sv
design/peak_normalize_gain.sv
test/testbench.sv
